FILE: design/pcxd_pkg.sv
// ----------------------------------------------------------------------------
// pcxd_pkg
// Shared types and constants of the run-length scan line decoder.
// ----------------------------------------------------------------------------
package pcxd_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLOR_MODE     = 2'd0;
    localparam logic [1:0] CFG_BYTES_PER_LINE = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd2;
    localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd3;

    localparam int CFG_DATA_W = 17;

    // Run header: both top bits set, count in the low six bits
    localparam logic [7:0] RUN_MARK  = 8'hC0;
    localparam logic [5:0] RUN_COUNT = 6'h3F;

    // Controller to datapath
    typedef struct packed {
        logic take_header;  // latch a run count
        logic take_data;    // latch the byte to decode and its count
        logic set_error;    // make the overrun sticky
        logic write_store;  // buffer the byte in plane 0 or 1
        logic advance;      // step position, plane and row
        logic load_pixel;   // fill the output register with a pixel
        logic load_error;   // fill the output register with the error result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic error_seen;
        logic finished;
        logic header;
        logic pending;
        logic overrun;
        logic count_zero;
        logic emit;
        logic store;
        logic last_byte;
        logic out_free;
    } status_t;

endpackage

FILE: design/pcxd_ctrl.sv
// ----------------------------------------------------------------------------
// pcxd_ctrl
// Controller: takes input bytes and sequences decoded bytes one per step.
// ----------------------------------------------------------------------------
module pcxd_ctrl
    import pcxd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_PUSH = 4'b0100,
        S_ERR  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (status.error_seen) begin
                        state_next = S_ERR;
                    end else if (status.finished) begin
                        state_next = S_IDLE;
                    end else if (!status.pending && status.header) begin
                        cmd.take_header = 1'b1;
                    end else begin
                        cmd.take_data = 1'b1;
                        if (status.overrun) begin
                            cmd.set_error = 1'b1;
                            state_next    = S_ERR;
                        end else if (!status.count_zero) begin
                            state_next = S_STEP;
                        end
                    end
                end
            end
            S_STEP: begin
                if (status.emit) begin
                    // wait in S_PUSH for the registered line store read
                    state_next = S_PUSH;
                end else begin
                    cmd.write_store = status.store;
                    cmd.advance     = 1'b1;
                    state_next      = status.last_byte ? S_IDLE : S_STEP;
                end
            end
            S_PUSH: begin
                if (status.out_free) begin
                    cmd.load_pixel = 1'b1;
                    cmd.advance    = 1'b1;
                    state_next     = status.last_byte ? S_IDLE : S_STEP;
                end
            end
            S_ERR: begin
                if (status.out_free) begin
                    cmd.load_error = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/pcxd_datapath.sv
// ----------------------------------------------------------------------------
// pcxd_datapath
// Datapath: configuration, position counters, line store and output register.
// ----------------------------------------------------------------------------
module pcxd_datapath
    import pcxd_pkg::*;
#(
    parameter int MAX_LINE_BYTES = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            s_code_byte,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_first,
    output logic [7:0]            m_out_second,
    output logic [7:0]            m_out_third,
    output logic [11:0]           m_pixel_column,
    output logic [15:0]           m_pixel_row,
    output logic                  m_last_of_run,
    output logic                  m_row_done,
    output logic                  m_image_done,
    output logic                  m_overrun_error
);

    localparam int POS_W = $clog2(MAX_LINE_BYTES);
    localparam int CNT_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int CMP_W = (CNT_W > 13) ? CNT_W : 13;
    localparam int SUM_W = CMP_W + 1;

    // Configuration
    logic        color_mode_reg;
    logic [12:0] bytes_per_line_reg;
    logic [12:0] image_width_reg;
    logic [16:0] image_height_reg;

    // Decode state
    logic             pending_reg;
    logic [5:0]       run_len_reg;
    logic [5:0]       remain_reg;
    logic [7:0]       byte_reg;
    logic [POS_W-1:0] pos_reg;
    logic [1:0]       plane_reg;
    logic [15:0]      row_reg;
    logic             error_reg;
    logic             finished_reg;

    // Line store, planes 0 and 1
    logic [7:0] plane0_mem [MAX_LINE_BYTES];
    logic [7:0] plane1_mem [MAX_LINE_BYTES];
    logic [7:0] rd0_reg;
    logic [7:0] rd1_reg;

    // Output register
    logic        out_valid_reg;
    logic [7:0]  out_first_reg;
    logic [7:0]  out_second_reg;
    logic [7:0]  out_third_reg;
    logic [11:0] out_col_reg;
    logic [15:0] out_row_reg;
    logic        out_last_reg;
    logic        out_rdone_reg;
    logic        out_idone_reg;
    logic        out_err_reg;

    logic [CMP_W-1:0] bpl_raw;
    logic [CMP_W-1:0] width_raw;
    logic [CMP_W-1:0] eff_bpl;
    logic [CMP_W-1:0] eff_width;
    logic [16:0]      eff_height;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] pos_inc;
    logic [5:0]       count_in;
    logic             below_width;
    logic             row_end;
    logic             last_row;
    logic             plane_end;
    logic [1:0]       plane_inc;
    logic [1:0]       plane_count;
    logic             out_free;

    // Out-of-range registers saturate into their legal ranges
    assign bpl_raw   = CMP_W'(bytes_per_line_reg);
    assign width_raw = CMP_W'(image_width_reg);

    always_comb begin
        if (bpl_raw == '0) begin
            eff_bpl = CMP_W'(1);
        end else if (bpl_raw > CMP_W'(MAX_LINE_BYTES)) begin
            eff_bpl = CMP_W'(MAX_LINE_BYTES);
        end else begin
            eff_bpl = bpl_raw;
        end

        if (width_raw == '0) begin
            eff_width = CMP_W'(1);
        end else if (width_raw > eff_bpl) begin
            eff_width = eff_bpl;
        end else begin
            eff_width = width_raw;
        end

        if (image_height_reg == '0) begin
            eff_height = 17'd1;
        end else if (image_height_reg > 17'd65536) begin
            eff_height = 17'd65536;
        end else begin
            eff_height = image_height_reg;
        end
    end

    assign pos_ext     = CMP_W'(pos_reg);
    assign pos_inc     = pos_ext + CMP_W'(1);
    assign below_width = (pos_ext < eff_width);
    assign row_end     = (pos_inc == eff_width);
    assign last_row    = ((17'(row_reg) + 17'd1) == eff_height);
    assign plane_end   = (pos_inc >= eff_bpl);
    assign plane_inc   = plane_reg + 2'd1;
    assign plane_count = color_mode_reg ? 2'd3 : 2'd1;
    assign count_in    = pending_reg ? run_len_reg : 6'd1;
    assign out_free    = !out_valid_reg || m_ready;

    always_comb begin
        status            = '0;
        status.error_seen = error_reg;
        status.finished   = finished_reg;
        status.header     = ((s_code_byte & RUN_MARK) == RUN_MARK);
        status.pending    = pending_reg;
        status.overrun    = (SUM_W'(pos_reg) + SUM_W'(count_in)) > SUM_W'(eff_bpl);
        status.count_zero = (count_in == '0);
        status.emit       = below_width && (!color_mode_reg || (plane_reg == 2'd2));
        status.store      = color_mode_reg && (plane_reg < 2'd2);
        status.last_byte  = (remain_reg == 6'd1);
        status.out_free   = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg     <= 1'b0;
            bytes_per_line_reg <= 13'd1;
            image_width_reg    <= 13'd1;
            image_height_reg   <= 17'd1;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_COLOR_MODE:     color_mode_reg     <= cfg_data[0];
                CFG_BYTES_PER_LINE: bytes_per_line_reg <= cfg_data[12:0];
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[12:0];
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= 1'b0;
            run_len_reg  <= '0;
            remain_reg   <= '0;
            pos_reg      <= '0;
            plane_reg    <= '0;
            row_reg      <= '0;
            error_reg    <= 1'b0;
            finished_reg <= 1'b0;
        end else begin
            if (cmd.take_header) begin
                pending_reg <= 1'b1;
                run_len_reg <= s_code_byte[5:0] & RUN_COUNT;
            end
            if (cmd.take_data) begin
                pending_reg <= 1'b0;
                remain_reg  <= count_in;
            end
            if (cmd.set_error) begin
                error_reg <= 1'b1;
            end
            if (cmd.advance) begin
                remain_reg <= remain_reg - 6'd1;
                if (plane_end) begin
                    pos_reg <= '0;
                    if (plane_inc >= plane_count) begin
                        plane_reg <= '0;
                        row_reg   <= row_reg + 16'd1;
                        if (last_row) begin
                            finished_reg <= 1'b1;
                        end
                    end else begin
                        plane_reg <= plane_inc;
                    end
                end else begin
                    pos_reg <= POS_W'(pos_inc);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_data) begin
            byte_reg <= s_code_byte;
        end
    end

    // Line store: one write and one registered read per plane each cycle
    always_ff @(posedge aclk) begin
        if (cmd.write_store && !plane_reg[0]) begin
            plane0_mem[pos_reg] <= byte_reg;
        end
        if (cmd.write_store && plane_reg[0]) begin
            plane1_mem[pos_reg] <= byte_reg;
        end
        rd0_reg <= plane0_mem[pos_reg];
        rd1_reg <= plane1_mem[pos_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_pixel || cmd.load_error) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            out_first_reg  <= byte_reg;
            out_second_reg <= color_mode_reg ? rd1_reg : 8'd0;
            out_third_reg  <= color_mode_reg ? rd0_reg : 8'd0;
            out_col_reg    <= 12'(pos_ext);
            out_row_reg    <= row_reg;
            out_last_reg   <= (remain_reg == 6'd1) || row_end;
            out_rdone_reg  <= row_end;
            out_idone_reg  <= row_end && last_row;
            out_err_reg    <= 1'b0;
        end else if (cmd.load_error) begin
            out_first_reg  <= '0;
            out_second_reg <= '0;
            out_third_reg  <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_last_reg   <= 1'b1;
            out_rdone_reg  <= 1'b0;
            out_idone_reg  <= 1'b0;
            out_err_reg    <= 1'b1;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_out_first     = out_first_reg;
    assign m_out_second    = out_second_reg;
    assign m_out_third     = out_third_reg;
    assign m_pixel_column  = out_col_reg;
    assign m_pixel_row     = out_row_reg;
    assign m_last_of_run   = out_last_reg;
    assign m_row_done      = out_rdone_reg;
    assign m_image_done    = out_idone_reg;
    assign m_overrun_error = out_err_reg;

endmodule

FILE: design/pcx_rle_scanline_decoder_unit.sv
// ----------------------------------------------------------------------------
// pcx_rle_scanline_decoder_unit
// Run-length scan line decoder: compressed bytes in, pixels out.
// ----------------------------------------------------------------------------
// Flow: a run header is taken in S_IDLE. Each decoded byte then takes one step
// of the controller: a byte that is buffered in plane 0 or 1 or that falls in
// the padding is stepped in S_STEP alone; a byte that yields a pixel passes on
// to S_PUSH, which follows the registered read of the line store and waits for
// a free output register. An overrun result is loaded from S_ERR when the
// output register is free. The output register lets the next byte in while a
// pixel waits to be taken. The line store is not cleared after reset, so the
// block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_unit
    import pcxd_pkg::*;
#(
    parameter int MAX_LINE_BYTES = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_code_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_first,
    output logic [7:0]            m_out_second,
    output logic [7:0]            m_out_third,
    output logic [11:0]           m_pixel_column,
    output logic [15:0]           m_pixel_row,
    output logic                  m_last_of_run,
    output logic                  m_row_done,
    output logic                  m_image_done,
    output logic                  m_overrun_error
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    pcxd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pcxd_datapath #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_code_byte     (s_code_byte),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_first     (m_out_first),
        .m_out_second    (m_out_second),
        .m_out_third     (m_out_third),
        .m_pixel_column  (m_pixel_column),
        .m_pixel_row     (m_pixel_row),
        .m_last_of_run   (m_last_of_run),
        .m_row_done      (m_row_done),
        .m_image_done    (m_image_done),
        .m_overrun_error (m_overrun_error)
    );

endmodule
